// ----- rtl/core/bdce_pkg.sv -----
// Shared constants, command and status types for the Bezier curve evaluator.
package bdce_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int T_W    = FRAC_BITS + 1;
  localparam int WORK_W = COORD_BITS + FRAC_BITS + 2;
  localparam int PROD_W = WORK_W + T_W + 1;

  localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << FRAC_BITS;
  localparam logic [WORK_W-1:0] HALF     = WORK_W'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_POINTS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic             load;
    logic             eval_start;
    logic             copy;
    logic             issue;
    logic             fetch;
    logic             result;
    logic             zero;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

// ----- rtl/core/bdce_if.sv -----
// Handshake channel interfaces for input items and curve results.
interface bdce_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        first_point;
  logic [16:0] t_param;

  modport source (output valid, operation, point_x, point_y, first_point, t_param,
                  input ready);
  modport sink (input valid, operation, point_x, point_y, first_point, t_param,
                output ready);
endinterface

interface bdce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] curve_x;
  logic [15:0] curve_y;
  logic        points_dropped;

  modport source (output valid, curve_x, curve_y, points_dropped, input ready);
  modport sink (input valid, curve_x, curve_y, points_dropped, output ready);
endinterface

// ----- rtl/core/bdce_dp.sv -----
// Datapath: point stores, working triangle memory, interpolation pipeline, rounding.
module bdce_dp import bdce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic                  first_point_i,
  input  logic [T_W-1:0]        t_param_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [COORD_BITS-1:0] curve_x_o,
  output logic [COORD_BITS-1:0] curve_y_o,
  output logic                  points_dropped_o
);

  logic [COORD_BITS-1:0] ctrl_x_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] ctrl_y_mem [MAX_POINTS];
  logic [WORK_W-1:0]     work_x_mem [MAX_POINTS];
  logic [WORK_W-1:0]     work_y_mem [MAX_POINTS];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [T_W-1:0]   t_q;

  logic [CNT_W-1:0] load_idx;
  logic             load_fits;

  logic [IDX_W-1:0] rd_b_idx;
  logic [WORK_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic              v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]  a1_q, a2_q, a3_q;
  logic signed [WORK_W-1:0] dx_q, dy_q, sx_q, sy_q, sx2_q, sy2_q;
  logic signed [PROD_W-1:0] px_d, py_d, px_q, py_q;
  logic [WORK_W-1:0] lx, ly;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic                  copy_v_q;
  logic [IDX_W-1:0]      copy_a_q;
  logic [WORK_W-1:0]     wx_copy, wy_copy;

  logic [WORK_W-1:0]     rnd_x, rnd_y;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_drop_q;

  // Load bookkeeping.
  always_comb begin
    load_idx  = first_point_i ? '0 : cnt_q;
    load_fits = load_idx < CNT_MAX;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    if (cmd_i.load) begin
      ovf_d = (first_point_i ? 1'b0 : ovf_q) | ~load_fits;
      cnt_d = load_fits ? load_idx + CNT_ONE : load_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_fits) begin
      ctrl_x_mem[load_idx[IDX_W-1:0]] <= point_x_i;
      ctrl_y_mem[load_idx[IDX_W-1:0]] <= point_y_i;
    end
    if (cmd_i.eval_start) begin
      t_q <= (t_param_i > T_ONE) ? T_ONE : t_param_i;
    end
  end

  // Copy control points into the triangle, widened to fixed point.
  always_ff @(posedge clk_i) begin
    cx_q     <= ctrl_x_mem[cmd_i.idx];
    cy_q     <= ctrl_y_mem[cmd_i.idx];
    copy_a_q <= cmd_i.idx;
  end

  assign wx_copy = {{(WORK_W-COORD_BITS-FRAC_BITS){cx_q[COORD_BITS-1]}}, cx_q,
                    {FRAC_BITS{1'b0}}};
  assign wy_copy = {{(WORK_W-COORD_BITS-FRAC_BITS){cy_q[COORD_BITS-1]}}, cy_q,
                    {FRAC_BITS{1'b0}}};

  // Interpolation pipeline: read, subtract, multiply, add and write back.
  assign rd_b_idx = cmd_i.idx + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    ax_q <= work_x_mem[cmd_i.idx];
    ay_q <= work_y_mem[cmd_i.idx];
    bx_q <= work_x_mem[rd_b_idx];
    by_q <= work_y_mem[rd_b_idx];
    if (copy_v_q) begin
      work_x_mem[copy_a_q] <= wx_copy;
      work_y_mem[copy_a_q] <= wy_copy;
    end else if (v3_q) begin
      work_x_mem[a3_q] <= lx;
      work_y_mem[a3_q] <= ly;
    end
  end

  assign px_d = dx_q * $signed({1'b0, t_q});
  assign py_d = dy_q * $signed({1'b0, t_q});
  assign lx   = sx2_q + px_q[FRAC_BITS +: WORK_W];
  assign ly   = sy2_q + py_q[FRAC_BITS +: WORK_W];

  always_ff @(posedge clk_i) begin
    a1_q  <= cmd_i.idx;
    dx_q  <= bx_q - ax_q;
    dy_q  <= by_q - ay_q;
    sx_q  <= ax_q;
    sy_q  <= ay_q;
    a2_q  <= a1_q;
    px_q  <= px_d;
    py_q  <= py_d;
    sx2_q <= sx_q;
    sy2_q <= sy_q;
    a3_q  <= a2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      copy_v_q <= 1'b0;
    end else begin
      v1_q     <= cmd_i.issue;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      copy_v_q <= cmd_i.copy;
    end
  end

  // Round half away from zero.
  assign rnd_x = ax_q + HALF - WORK_W'(ax_q[WORK_W-1]);
  assign rnd_y = ay_q + HALF - WORK_W'(ay_q[WORK_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      out_x_q    <= cmd_i.zero ? '0 : rnd_x[FRAC_BITS +: COORD_BITS];
      out_y_q    <= cmd_i.zero ? '0 : rnd_y[FRAC_BITS +: COORD_BITS];
      out_drop_q <= ovf_q;
    end
  end

  assign status_o.busy     = v1_q | v2_q | v3_q | copy_v_q;
  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign status_o.count    = cnt_q;

  assign out_valid_o      = out_valid_q;
  assign curve_x_o        = out_x_q;
  assign curve_y_o        = out_y_q;
  assign points_dropped_o = out_drop_q;

  a_write_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_v_q |-> !v3_q) else $error("copy and interpolation write collide");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX) else $error("point count above capacity");

  a_result_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a waiting output");

endmodule

// ----- rtl/core/bdce_ctrl.sv -----
// Controller: sequences loads, triangle copy, interpolation levels and rounding.
module bdce_ctrl import bdce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_COPY      = 7'b0000010,
    S_COPY_WAIT = 7'b0000100,
    S_LEVEL     = 7'b0001000,
    S_DRAIN     = 7'b0010000,
    S_FETCH     = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic             zero_q, zero_d;
  logic             in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    i_d     = i_q;
    zero_d  = zero_q;
    cmd_o   = '0;
    cmd_o.idx  = i_q[IDX_W-1:0];
    cmd_o.zero = zero_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_op_i == OP_LOAD) begin
          cmd_o.load = 1'b1;
        end else if (in_fire && in_op_i == OP_EVAL) begin
          cmd_o.eval_start = 1'b1;
          n_d    = status_i.count;
          i_d    = '0;
          zero_d = (status_i.count == '0);
          state_d = (status_i.count == '0) ? S_RESULT : S_COPY;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        i_d = i_q + CNT_ONE;
        if (i_q == n_q - CNT_ONE) begin
          state_d = S_COPY_WAIT;
        end
      end
      S_COPY_WAIT: begin
        if (!status_i.busy) begin
          k_d = CNT_ONE;
          i_d = '0;
          state_d = (n_q == CNT_ONE) ? S_FETCH : S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd_o.issue = 1'b1;
        i_d = i_q + CNT_ONE;
        if (i_q == n_q - k_q - CNT_ONE) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.busy) begin
          i_d = '0;
          if (k_q == n_q - CNT_ONE) begin
            state_d = S_FETCH;
          end else begin
            k_d = k_q + CNT_ONE;
            state_d = S_LEVEL;
          end
        end
      end
      S_FETCH: begin
        cmd_o.idx = '0;
        cmd_o.fetch = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.result = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      k_q     <= '0;
      i_q     <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      i_q     <= i_d;
      zero_q  <= zero_d;
    end
  end

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (i_q + k_q < n_q)) else $error("interpolation index out of range");

  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.copy |-> (i_q < n_q)) else $error("copy index out of range");

  a_level_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && state_d == S_LEVEL) |-> !status_i.busy)
    else $error("next level starts before write back");

endmodule

// ----- rtl/core/bezier_de_casteljau_eval.sv -----
// Top level of the De Casteljau Bezier curve evaluator.
// A load item stores one control point (up to 16 per set; first_point starts a new set,
// further points are dropped and flagged). An evaluate item copies the n stored
// points into the working triangle, runs the n(n-1)/2 interpolations through one
// four-stage read, subtract, multiply and add pipeline at one per cycle within a
// level, waits for that pipeline to drain after each of the n - 1 levels, then
// reads and rounds the apex. Input is taken only while no evaluation runs; a
// finished result sits in an output register, so a load or a new evaluation is
// accepted while it waits to be transferred, and an evaluation that finishes
// while an earlier result still waits holds until it is taken.
module bezier_de_casteljau_eval import bdce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdce_in_if.sink    in_i,
  bdce_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bdce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdce_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .point_x_i        (in_i.point_x),
    .point_y_i        (in_i.point_y),
    .first_point_i    (in_i.first_point),
    .t_param_i        (in_i.t_param),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .curve_x_o        (out_o.curve_x),
    .curve_y_o        (out_o.curve_y),
    .points_dropped_o (out_o.points_dropped)
  );

endmodule
